@@ src/packed_voxel_field_store_assert.svh @@
// assertion macros for the packed voxel field store checker
`ifndef PACKED_VOXEL_FIELD_STORE_ASSERT_SVH
`define PACKED_VOXEL_FIELD_STORE_ASSERT_SVH

// condition in one cycle implies consequence in the next
`define PVFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("packed voxel field store check failed");

// condition implies consequence in the same cycle
`define PVFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("packed voxel field store check failed");

`endif

@@ src/pvfs_pkg.sv @@
// shared constants and types for the packed voxel field store
`default_nettype none

package pvfs_pkg;

  localparam int unsigned SIDE_DEF       = 4;
  localparam int unsigned FIELD_BITS_DEF = 12;
  localparam int unsigned WORD_BITS_DEF  = 32;
  localparam int unsigned NWORDS_DEF     =
    (SIDE_DEF * SIDE_DEF * SIDE_DEF * FIELD_BITS_DEF + WORD_BITS_DEF - 1) / WORD_BITS_DEF;

  localparam int unsigned COORD_W = 2;
  localparam int unsigned VALUE_W = 12;
  localparam int unsigned OUT_W   = 12;

  typedef enum logic {
    ACT_READ  = 1'b0,
    ACT_WRITE = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_MOD,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

@@ src/pvfs_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none

module pvfs_ram #(
  parameter int unsigned WIDTH = pvfs_pkg::WORD_BITS_DEF,
  parameter int unsigned DEPTH = pvfs_pkg::NWORDS_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/packed_voxel_field_store.sv @@
// packed voxel field store: one memory of packed fields, read-modify-write sequencer
// one request at a time; an in-cube request passes DIV, RD, then MOD once per memory word
// the field touches (one or two), one word per cycle; a read then waits in DONE until the
// result register is free, and out_valid_o rises as it leaves DONE; a write returns to idle
// from the last MOD; after reset a clearing pass writes zero to all NWORDS words, during
// which no request is accepted
`default_nettype none

module packed_voxel_field_store #(
  parameter int unsigned SIDE       = pvfs_pkg::SIDE_DEF,
  parameter int unsigned FIELD_BITS = pvfs_pkg::FIELD_BITS_DEF,
  parameter int unsigned WORD_BITS  = pvfs_pkg::WORD_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         action_i,
  input  wire logic [pvfs_pkg::COORD_W-1:0] coord_x_i,
  input  wire logic [pvfs_pkg::COORD_W-1:0] coord_y_i,
  input  wire logic [pvfs_pkg::COORD_W-1:0] coord_z_i,
  input  wire logic [pvfs_pkg::VALUE_W-1:0] write_value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [pvfs_pkg::OUT_W-1:0]   read_value_o
);

  localparam int unsigned NCELL  = SIDE * SIDE * SIDE;
  localparam int unsigned IDX_W  = $clog2(NCELL);
  localparam int unsigned TOTAL  = NCELL * FIELD_BITS;
  localparam int unsigned FB_W   = $clog2(TOTAL + WORD_BITS + 1);
  localparam int unsigned NWORDS = (TOTAL + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned OFF_W  = $clog2(WORD_BITS);
  localparam int unsigned CNT_W  = $clog2(WORD_BITS + FIELD_BITS + 1);
  localparam int unsigned DIV_SH = IDX_W;
  localparam longint unsigned DIV_K = (longint'(FIELD_BITS) << DIV_SH) / WORD_BITS;
  localparam int unsigned K_W    = DIV_SH + 3;
  localparam int unsigned PROD_W = IDX_W + K_W;

  pvfs_pkg::state_e state_q, state_d;

  logic [AW-1:0]                  clr_q, clr_d;
  logic                           in_cube_q, in_cube_d;
  logic                           write_q, write_d;
  logic [FB_W-1:0]                fb_q, fb_d;
  logic [PROD_W-1:0]              prod_q, prod_d;
  logic [AW-1:0]                  word_q, word_d;
  logic [OFF_W-1:0]               off_q, off_d;
  logic [CNT_W-1:0]               rem_q, rem_d;
  logic [CNT_W-1:0]               from_q, from_d;
  logic [FIELD_BITS-1:0]          val_q, val_d;
  logic [FIELD_BITS-1:0]          acc_q, acc_d;
  logic                           out_valid_q, out_valid_d;
  logic [pvfs_pkg::OUT_W-1:0]     out_value_q, out_value_d;

  logic                  accept;
  logic                  out_free;
  logic                  in_cube;
  logic [IDX_W-1:0]      idx;
  logic [FB_W-1:0]       q_est;
  logic [FB_W-1:0]       q_mul;
  logic [FB_W-1:0]       r_est;
  logic                  corr;
  logic [CNT_W-1:0]      room;
  logic [CNT_W-1:0]      len;
  logic [WORD_BITS-1:0]  lmask;
  logic [WORD_BITS-1:0]  fmask;
  logic [WORD_BITS-1:0]  piece;
  logic [WORD_BITS-1:0]  merged;
  logic [FIELD_BITS-1:0] got;
  logic                  last;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  pvfs_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NWORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // voxel index and cube bounds
  assign in_cube = (32'(coord_x_i) < SIDE) && (32'(coord_y_i) < SIDE) &&
                   (32'(coord_z_i) < SIDE);
  assign idx     = IDX_W'(32'(coord_z_i) * SIDE * SIDE + 32'(coord_y_i) * SIDE +
                          32'(coord_x_i));

  // word index by reciprocal multiply, one correction step
  assign q_est = FB_W'(prod_q >> DIV_SH);
  assign q_mul = q_est * FB_W'(WORD_BITS);
  assign r_est = fb_q - q_mul;
  assign corr  = (r_est >= FB_W'(WORD_BITS));

  // per-word slice of the field
  assign room   = CNT_W'(WORD_BITS) - CNT_W'(off_q);
  assign len    = (rem_q < room) ? rem_q : room;
  assign lmask  = ~({WORD_BITS{1'b1}} << len);
  assign fmask  = lmask << off_q;
  assign piece  = (WORD_BITS'(val_q >> from_q) & lmask) << off_q;
  assign merged = (ram_rdata & ~fmask) | piece;
  assign got    = FIELD_BITS'((ram_rdata >> off_q) & lmask) << from_q;
  assign last   = (rem_q == len) || (word_q == AW'(NWORDS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pvfs_pkg::ST_CLEAR: begin
        if (clr_q == AW'(NWORDS - 1)) begin
          state_d = pvfs_pkg::ST_IDLE;
        end
      end
      pvfs_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = pvfs_pkg::ST_DIV;
        end
      end
      pvfs_pkg::ST_DIV: begin
        if (in_cube_q) begin
          state_d = pvfs_pkg::ST_RD;
        end else if (write_q) begin
          state_d = pvfs_pkg::ST_IDLE;
        end else begin
          state_d = pvfs_pkg::ST_DONE;
        end
      end
      pvfs_pkg::ST_RD: begin
        state_d = pvfs_pkg::ST_MOD;
      end
      pvfs_pkg::ST_MOD: begin
        if (last) begin
          state_d = write_q ? pvfs_pkg::ST_IDLE : pvfs_pkg::ST_DONE;
        end
      end
      pvfs_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = pvfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pvfs_pkg::ST_CLEAR;
      end
    endcase
  end

  // memory port and handshake outputs
  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = word_q;
    ram_wdata  = merged;
    ram_re     = 1'b0;
    ram_raddr  = word_q;
    unique case (state_q)
      pvfs_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      pvfs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      pvfs_pkg::ST_DIV: begin
      end
      pvfs_pkg::ST_RD: begin
        ram_re = 1'b1;
      end
      pvfs_pkg::ST_MOD: begin
        ram_we    = write_q;
        ram_re    = !last;
        ram_raddr = AW'(word_q + 1'b1);
      end
      pvfs_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    clr_d       = clr_q;
    in_cube_d   = in_cube_q;
    write_d     = write_q;
    fb_d        = fb_q;
    prod_d      = prod_q;
    word_d      = word_q;
    off_d       = off_q;
    rem_d       = rem_q;
    from_d      = from_q;
    val_d       = val_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_value_d = out_value_q;
    case (state_q)
      pvfs_pkg::ST_CLEAR: begin
        clr_d = AW'(clr_q + 1'b1);
      end
      pvfs_pkg::ST_IDLE: begin
        if (accept) begin
          in_cube_d = in_cube;
          write_d   = (action_i == pvfs_pkg::ACT_WRITE);
          fb_d      = FB_W'(32'(idx) * FIELD_BITS);
          prod_d    = PROD_W'(idx) * PROD_W'(DIV_K);
          val_d     = FIELD_BITS'(write_value_i);
          acc_d     = '0;
          rem_d     = CNT_W'(FIELD_BITS);
          from_d    = '0;
        end
      end
      pvfs_pkg::ST_DIV: begin
        word_d = corr ? AW'(q_est + 1'b1) : AW'(q_est);
        off_d  = corr ? OFF_W'(r_est - FB_W'(WORD_BITS)) : OFF_W'(r_est);
      end
      pvfs_pkg::ST_MOD: begin
        acc_d  = acc_q | got;
        rem_d  = rem_q - len;
        from_d = from_q + len;
        off_d  = '0;
        word_d = AW'(word_q + 1'b1);
      end
      pvfs_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = pvfs_pkg::OUT_W'(acc_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pvfs_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_cube_q   <= in_cube_d;
    write_q     <= write_d;
    fb_q        <= fb_d;
    prod_q      <= prod_d;
    word_q      <= word_d;
    off_q       <= off_d;
    rem_q       <= rem_d;
    from_q      <= from_d;
    val_q       <= val_d;
    acc_q       <= acc_d;
    out_value_q <= out_value_d;
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_value_q;

endmodule

`default_nettype wire

@@ src/pvfs_checker.sv @@
// port-level checker for the packed voxel field store, bound to the top level
`default_nettype none

`include "packed_voxel_field_store_assert.svh"

module pvfs_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic                         action_i,
  input wire logic [pvfs_pkg::COORD_W-1:0] coord_x_i,
  input wire logic [pvfs_pkg::COORD_W-1:0] coord_y_i,
  input wire logic [pvfs_pkg::COORD_W-1:0] coord_z_i,
  input wire logic [pvfs_pkg::VALUE_W-1:0] write_value_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [pvfs_pkg::OUT_W-1:0]   read_value_o
);

  logic in_take;
  logic coord_any;

  assign in_take   = in_valid_i && in_ready_o;
  assign coord_any = |{coord_x_i, coord_y_i, coord_z_i, write_value_i};

  // one request in flight: input closes right after a request is taken
  `PVFS_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_take, !in_ready_o)

  // a result is only posted as the sequencer returns to idle
  `PVFS_ASSERT_NOW(a_result_at_idle, clk_i, rst_ni, $rose(out_valid_o), in_ready_o)

  // a taken request never makes a result appear in the next cycle
  `PVFS_ASSERT_NEXT(a_no_early_result, clk_i, rst_ni,
                    in_take && !out_valid_o && (action_i || !coord_any || coord_any),
                    !out_valid_o)

  // stalled result holds
  `PVFS_ASSERT_NEXT(a_result_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(read_value_o))

endmodule

bind packed_voxel_field_store pvfs_checker u_pvfs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .action_i      (action_i),
  .coord_x_i     (coord_x_i),
  .coord_y_i     (coord_y_i),
  .coord_z_i     (coord_z_i),
  .write_value_i (write_value_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .read_value_o  (read_value_o)
);

`default_nettype wire

@@ bench/voxel_field_checker.sv @@
// request tracker and field predictor for the packed voxel field store bench
`timescale 1ns / 100ps
`default_nettype none

module voxel_field_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         req_valid_i,
  input  wire logic                         req_ready_i,
  input  wire logic                         action_i,
  input  wire logic [pvfs_pkg::COORD_W-1:0] coord_x_i,
  input  wire logic [pvfs_pkg::COORD_W-1:0] coord_y_i,
  input  wire logic [pvfs_pkg::COORD_W-1:0] coord_z_i,
  input  wire logic [pvfs_pkg::VALUE_W-1:0] write_value_i,
  input  wire logic                         rsp_valid_i,
  input  wire logic                         rsp_ready_i,
  input  wire logic [pvfs_pkg::OUT_W-1:0]   read_value_i,
  output int                                fail_count_o,
  output int                                pending_o
);

  logic [pvfs_pkg::WORD_BITS_DEF-1:0] packed_image [pvfs_pkg::NWORDS_DEF];
  logic [pvfs_pkg::OUT_W-1:0]         expected_reads [$];
  int                                 mismatches = 0;

  always @(posedge clk_i or negedge rst_ni) begin : track
    int unsigned                base;
    int unsigned                pos;
    bit                         in_cube;
    logic [pvfs_pkg::OUT_W-1:0] gathered;
    logic [pvfs_pkg::OUT_W-1:0] oldest;
    if (!rst_ni) begin
      for (int w = 0; w < pvfs_pkg::NWORDS_DEF; w++) packed_image[w] = '0;
      expected_reads.delete();
      mismatches = 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_reads.size() == 0) begin
          $error("read_value: expected no result, actual %0d", read_value_i);
          mismatches++;
        end else begin
          oldest = expected_reads.pop_front();
          if (oldest !== read_value_i) begin
            $error("read_value: expected %0d, actual %0d", oldest, read_value_i);
            mismatches++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        in_cube = coord_x_i < pvfs_pkg::SIDE_DEF && coord_y_i < pvfs_pkg::SIDE_DEF &&
                  coord_z_i < pvfs_pkg::SIDE_DEF;
        base = (coord_z_i * pvfs_pkg::SIDE_DEF * pvfs_pkg::SIDE_DEF +
                coord_y_i * pvfs_pkg::SIDE_DEF + coord_x_i) * pvfs_pkg::FIELD_BITS_DEF;
        if (action_i == pvfs_pkg::ACT_WRITE) begin
          if (in_cube) begin
            for (int b = 0; b < pvfs_pkg::FIELD_BITS_DEF; b++) begin
              pos = base + b;
              packed_image[pos / pvfs_pkg::WORD_BITS_DEF][pos % pvfs_pkg::WORD_BITS_DEF] =
                (b < pvfs_pkg::VALUE_W) ? write_value_i[b] : 1'b0;
            end
          end
        end else begin
          gathered = '0;
          if (in_cube) begin
            for (int b = 0; b < pvfs_pkg::FIELD_BITS_DEF && b < pvfs_pkg::OUT_W; b++) begin
              pos = base + b;
              gathered[b] =
                packed_image[pos / pvfs_pkg::WORD_BITS_DEF][pos % pvfs_pkg::WORD_BITS_DEF];
            end
          end
          expected_reads.push_back(gathered);
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_reads.size();
  end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// stimulus, stall control and verdict for the packed voxel field store
`timescale 1ns / 100ps
`default_nettype none

module testbench;

  localparam int RANDOM_ITEMS   = 1650;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;

  logic                         clk;
  logic                         rst_n       = 1'b0;
  logic                         req_valid   = 1'b0;
  logic                         req_ready;
  logic                         req_action  = pvfs_pkg::ACT_READ;
  logic [pvfs_pkg::COORD_W-1:0] req_x       = '0;
  logic [pvfs_pkg::COORD_W-1:0] req_y       = '0;
  logic [pvfs_pkg::COORD_W-1:0] req_z       = '0;
  logic [pvfs_pkg::VALUE_W-1:0] req_value   = '0;
  logic                         rsp_valid;
  logic                         rsp_ready   = 1'b0;
  logic [pvfs_pkg::OUT_W-1:0]   rsp_value;

  int check_fails;
  int reads_outstanding;
  int writes_sent = 0;
  int reads_sent  = 0;
  int items_sent  = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  packed_voxel_field_store dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (req_valid),
    .in_ready_o    (req_ready),
    .action_i      (req_action),
    .coord_x_i     (req_x),
    .coord_y_i     (req_y),
    .coord_z_i     (req_z),
    .write_value_i (req_value),
    .out_valid_o   (rsp_valid),
    .out_ready_i   (rsp_ready),
    .read_value_o  (rsp_value)
  );

  voxel_field_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_valid_i   (req_valid),
    .req_ready_i   (req_ready),
    .action_i      (req_action),
    .coord_x_i     (req_x),
    .coord_y_i     (req_y),
    .coord_z_i     (req_z),
    .write_value_i (req_value),
    .rsp_valid_i   (rsp_valid),
    .rsp_ready_i   (rsp_ready),
    .read_value_i  (rsp_value),
    .fail_count_o  (check_fails),
    .pending_o     (reads_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp_ready <= calm || ($urandom_range(0, 99) >= 17);
  end

  always @(posedge clk) begin
    if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("packed_voxel_field_store regression: fail");
        $finish;
      end
    end
  end

  task automatic send_request(pvfs_pkg::action_e act, logic [pvfs_pkg::COORD_W-1:0] x,
                              logic [pvfs_pkg::COORD_W-1:0] y,
                              logic [pvfs_pkg::COORD_W-1:0] z,
                              logic [pvfs_pkg::VALUE_W-1:0] value);
    while (!calm && $urandom_range(0, 99) < 17) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid  <= 1'b1;
    req_action <= act;
    req_x      <= x;
    req_y      <= y;
    req_z      <= z;
    req_value  <= value;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    items_sent++;
    if (act == pvfs_pkg::ACT_WRITE) writes_sent++;
    else reads_sent++;
  endtask

  function automatic logic [pvfs_pkg::VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return '0;
    if (sel < 20) return '1;
    return pvfs_pkg::VALUE_W'($urandom_range(0, (1 << pvfs_pkg::VALUE_W) - 1));
  endfunction

  initial begin
    logic [pvfs_pkg::COORD_W-1:0] x;
    logic [pvfs_pkg::COORD_W-1:0] y;
    logic [pvfs_pkg::COORD_W-1:0] z;
    int                           mix;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // cleared store, then neighbors around word boundaries
    send_request(pvfs_pkg::ACT_READ,  2'd0, 2'd0, 2'd0, 12'hABC);
    send_request(pvfs_pkg::ACT_READ,  2'd3, 2'd3, 2'd3, 12'hFFF);
    send_request(pvfs_pkg::ACT_WRITE, 2'd0, 2'd0, 2'd0, 12'hFFF);
    send_request(pvfs_pkg::ACT_WRITE, 2'd2, 2'd0, 2'd0, 12'hFFF);
    send_request(pvfs_pkg::ACT_WRITE, 2'd1, 2'd0, 2'd0, 12'h000);
    send_request(pvfs_pkg::ACT_READ,  2'd0, 2'd0, 2'd0, 12'h000);
    send_request(pvfs_pkg::ACT_READ,  2'd1, 2'd0, 2'd0, 12'hFFF);
    send_request(pvfs_pkg::ACT_READ,  2'd2, 2'd0, 2'd0, 12'h000);
    send_request(pvfs_pkg::ACT_WRITE, 2'd1, 2'd0, 2'd0, 12'hAAA);
    send_request(pvfs_pkg::ACT_READ,  2'd1, 2'd0, 2'd0, 12'h555);
    send_request(pvfs_pkg::ACT_READ,  2'd2, 2'd0, 2'd0, 12'h000);
    send_request(pvfs_pkg::ACT_WRITE, 2'd3, 2'd0, 2'd0, 12'h555);
    send_request(pvfs_pkg::ACT_READ,  2'd2, 2'd0, 2'd0, 12'h000);
    send_request(pvfs_pkg::ACT_READ,  2'd3, 2'd0, 2'd0, 12'h000);
    send_request(pvfs_pkg::ACT_WRITE, 2'd2, 2'd0, 2'd0, 12'h000);
    send_request(pvfs_pkg::ACT_READ,  2'd1, 2'd0, 2'd0, 12'hFFF);
    send_request(pvfs_pkg::ACT_READ,  2'd2, 2'd0, 2'd0, 12'hFFF);
    send_request(pvfs_pkg::ACT_READ,  2'd3, 2'd0, 2'd0, 12'hFFF);
    send_request(pvfs_pkg::ACT_WRITE, 2'd3, 2'd3, 2'd3, 12'hFFF);
    send_request(pvfs_pkg::ACT_READ,  2'd3, 2'd3, 2'd3, 12'h000);
    send_request(pvfs_pkg::ACT_READ,  2'd2, 2'd3, 2'd3, 12'h000);
    send_request(pvfs_pkg::ACT_WRITE, 2'd1, 2'd1, 2'd0, 12'h5A5);
    send_request(pvfs_pkg::ACT_READ,  2'd1, 2'd1, 2'd0, 12'h000);

    while (items_sent < RANDOM_ITEMS) begin
      calm = items_sent >= 600 && items_sent < 900;
      x = pvfs_pkg::COORD_W'($urandom_range(0, 3));
      y = pvfs_pkg::COORD_W'($urandom_range(0, 3));
      z = pvfs_pkg::COORD_W'($urandom_range(0, 3));
      mix = $urandom_range(0, 99);
      if (mix < 20) begin
        send_request(pvfs_pkg::ACT_WRITE, x, y, z, pick_value());
        send_request(pvfs_pkg::ACT_READ, x, y, z, pick_value());
      end else if (mix < 60) begin
        send_request(pvfs_pkg::ACT_WRITE, x, y, z, pick_value());
      end else begin
        send_request(pvfs_pkg::ACT_READ, x, y, z, pick_value());
      end
    end
    calm = 1'b0;
    req_valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (reads_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d writes and %0d reads over the whole cube, straddled fields included,",
             writes_sent, reads_sent);
    $display("with random gaps on the request side and random stalls on the result side");
    if (check_fails == 0 && reads_outstanding == 0) begin
      $display("packed_voxel_field_store regression: pass");
    end else begin
      $display("packed_voxel_field_store regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
